// File: hdl/leu_pkg.sv
// shared types and constants for the lorenz euler integrator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package leu_pkg;

	localparam int COEF_W  = 32;
	localparam int DT_W    = 20;
	localparam int CNT_W   = 16;
	localparam int BAND_W  = 2;
	localparam int ADDR_W  = 3;
	localparam int POS_W   = 32;
	localparam int CFG_FRAC = 20;

	localparam logic [ADDR_W-1:0] REG_SIGMA     = 3'd0;
	localparam logic [ADDR_W-1:0] REG_RHO       = 3'd1;
	localparam logic [ADDR_W-1:0] REG_BETA      = 3'd2;
	localparam logic [ADDR_W-1:0] REG_TIME_STEP = 3'd3;
	localparam logic [ADDR_W-1:0] REG_TOTAL     = 3'd4;
	localparam logic [ADDR_W-1:0] REG_FIRST_END = 3'd5;
	localparam logic [ADDR_W-1:0] REG_SECOND_END = 3'd6;

	localparam logic [BAND_W-1:0] BAND_RED   = 2'd0;
	localparam logic [BAND_W-1:0] BAND_GREEN = 2'd1;
	localparam logic [BAND_W-1:0] BAND_BLUE  = 2'd2;

	typedef enum logic [2:0] {
		OP_DX,
		OP_DY,
		OP_XY,
		OP_DZ,
		OP_NX,
		OP_NY,
		OP_NZ
	} op_t;

	typedef struct packed {
		logic load;
		logic mul_go;
		logic commit;
		op_t  op;
	} cmd_t;

endpackage

`default_nettype wire

// File: hdl/leu_mul.sv
// shared multi-cycle fixed-point multiplier, 16-bit digit per cycle
// floor shift by FRAC_BITS or by the coefficient fraction, then saturation; uses leu_pkg
`timescale 1ns / 1ps
`default_nettype none

module leu_mul
	import leu_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 20
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   go,
	input  wire logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] a,
	input  wire logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] b,
	input  wire logic                   frac_sh,
	output logic      [COORD_WIDTH-1:0] res,
	output logic                        sat,
	output logic                        done
);

	localparam int W    = COORD_WIDTH;
	localparam int OPW  = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
	localparam int NDIG = (OPW + 15) / 16;
	localparam int DW   = NDIG * 16;
	localparam int PW   = 2 * OPW;
	localparam int CW   = $clog2(NDIG + 1);
	localparam logic [PW-1:0] MAX_MAG = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [PW-1:0] MIN_MAG = MAX_MAG + 1'b1;
	localparam logic [W-1:0]  MAXV    = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  MINV    = {1'b1, {(W-1){1'b0}}};

	function automatic logic [OPW-1:0] mag(input logic [OPW-1:0] v);
		return v[OPW-1] ? (~v + 1'b1) : v;
	endfunction

	logic [OPW-1:0]   ua_q;
	logic [DW-1:0]    ub_q;
	logic [PW-1:0]    acc_q;
	logic             neg_q;
	logic             sh_q;
	logic [CW-1:0]    cnt_q;
	logic             fin_q;
	logic             done_q;
	logic [W-1:0]     res_q;
	logic             sat_q;

	logic [OPW+15:0]  pp;
	logic [PW-1:0]    q_sel;
	logic             rem_sel;
	logic [PW-1:0]    q1;
	logic [W-1:0]     res_d;
	logic             sat_d;

	assign pp = ua_q * ub_q[DW-1 -: 16];

	always_comb begin
		q_sel   = sh_q ? (acc_q >> FRAC_BITS) : (acc_q >> CFG_FRAC);
		rem_sel = sh_q ? (|acc_q[FRAC_BITS-1:0]) : (|acc_q[CFG_FRAC-1:0]);
		q1      = q_sel + PW'(neg_q & rem_sel);
		sat_d   = 1'b0;
		if (!neg_q) begin
			if (q1 > MAX_MAG) begin
				res_d = MAXV;
				sat_d = 1'b1;
			end else begin
				res_d = q1[W-1:0];
			end
		end else begin
			if (q1 > MIN_MAG) begin
				res_d = MINV;
				sat_d = 1'b1;
			end else begin
				res_d = ~q1[W-1:0] + 1'b1;
			end
		end
	end

	// sequencing flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (go) begin
			cnt_q  <= CW'(NDIG);
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				fin_q <= 1'b1;
			end
		end else if (fin_q) begin
			fin_q  <= 1'b0;
			done_q <= 1'b1;
		end
	end

	// operands, accumulator and result
	always_ff @(posedge clk) begin
		if (go) begin
			ua_q  <= mag(a);
			ub_q  <= DW'(mag(b));
			neg_q <= a[OPW-1] ^ b[OPW-1];
			sh_q  <= frac_sh;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			acc_q <= (acc_q << 16) + PW'(pp);
			ub_q  <= ub_q << 16;
		end else if (fin_q) begin
			res_q <= res_d;
			sat_q <= sat_d;
		end
	end

	assign res  = res_q;
	assign sat  = sat_q;
	assign done = done_q;

endmodule

`default_nettype wire

// File: hdl/leu_datapath.sv
// datapath: point and step registers, saturating add/sub, operand routing,
// output register; instantiates leu_mul, uses leu_pkg
`timescale 1ns / 1ps
`default_nettype none

module leu_datapath
	import leu_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 20
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cmd_t                     cmd,
	input  wire logic                     restart,
	input  wire logic signed [COEF_W-1:0] sigma,
	input  wire logic signed [COEF_W-1:0] rho,
	input  wire logic signed [COEF_W-1:0] beta,
	input  wire logic        [DT_W-1:0]   time_step,
	input  wire logic        [CNT_W-1:0]  total_steps,
	input  wire logic        [CNT_W-1:0]  first_band_end,
	input  wire logic        [CNT_W-1:0]  second_band_end,
	output logic                          mul_done,
	output logic             [POS_W-1:0]  pos_x,
	output logic             [POS_W-1:0]  pos_y,
	output logic             [POS_W-1:0]  pos_z,
	output logic             [CNT_W-1:0]  step_index,
	output logic             [BAND_W-1:0] color_band,
	output logic                          run_last,
	output logic                          saturated
);

	localparam int W   = COORD_WIDTH;
	localparam int OPW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
	localparam int BW  = ((COORD_WIDTH > 52) ? COORD_WIDTH : 52) + 1;
	localparam int LSH = (FRAC_BITS >= CFG_FRAC) ? (FRAC_BITS - CFG_FRAC) : 0;
	localparam int RSH = (FRAC_BITS < CFG_FRAC) ? (CFG_FRAC - FRAC_BITS) : 0;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] ONE  = (FRAC_BITS >= W - 1) ? MAXV : (W'(1) << FRAC_BITS);

	// {saturated, value}
	function automatic logic [W:0] sat_sum(input logic [W-1:0] p, input logic [W-1:0] q,
			input logic sub);
		logic [W:0] s;
		s = sub ? ({p[W-1], p} - {q[W-1], q}) : ({p[W-1], p} + {q[W-1], q});
		if (s[W] != s[W-1]) begin
			return {1'b1, s[W] ? MINV : MAXV};
		end
		return {1'b0, s[W-1:0]};
	endfunction

	function automatic logic [OPW-1:0] ext(input logic [W-1:0] v);
		return OPW'($signed(v));
	endfunction

	logic [W-1:0]       x_q, y_q, z_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [W-1:0]       dx_q, dy_q, dz_q, t_q;
	logic [CNT_W-1:0]   idx_q;
	logic [BAND_W-1:0]  band_q;
	logic               last_q;
	logic               sat_q;
	logic [POS_W-1:0]   out_x_q, out_y_q, out_z_q;
	logic [CNT_W-1:0]   out_idx_q;
	logic [BAND_W-1:0]  out_band_q;
	logic               out_last_q;
	logic               out_sat_q;

	logic signed [BW-1:0] rho_sh;
	logic [W-1:0]       rho_c;
	logic               rho_sat;
	logic [W:0]         diff_yx, diff_rz, wb;
	logic [OPW-1:0]     op_a, op_b;
	logic               op_frac, go_sat;
	logic [W-1:0]       wb_p, wb_q;
	logic               wb_sub;
	logic [W-1:0]       m_res;
	logic               m_sat;
	logic [CNT_W-1:0]   eff_idx;
	logic [BAND_W-1:0]  band_d;
	logic               last_d;

	// rho aligned to the coordinate fraction
	always_comb begin
		rho_sh  = (BW'(rho) <<< LSH) >>> RSH;
		rho_sat = !((&rho_sh[BW-1:W-1]) || !(|rho_sh[BW-1:W-1]));
		rho_c   = rho_sat ? (rho_sh[BW-1] ? MINV : MAXV) : rho_sh[W-1:0];
	end

	assign diff_yx = sat_sum(y_q, x_q, 1'b1);
	assign diff_rz = sat_sum(rho_c, z_q, 1'b1);

	// multiplier operands per step
	always_comb begin
		op_a    = '0;
		op_b    = '0;
		op_frac = 1'b0;
		go_sat  = 1'b0;
		case (cmd.op)
			OP_DX: begin
				op_a   = OPW'(sigma);
				op_b   = ext(diff_yx[W-1:0]);
				go_sat = diff_yx[W];
			end
			OP_DY: begin
				op_a    = ext(x_q);
				op_b    = ext(diff_rz[W-1:0]);
				op_frac = 1'b1;
				go_sat  = diff_rz[W];
			end
			OP_XY: begin
				op_a    = ext(x_q);
				op_b    = ext(y_q);
				op_frac = 1'b1;
			end
			OP_DZ: begin
				op_a = OPW'(beta);
				op_b = ext(z_q);
			end
			OP_NX: begin
				op_a = OPW'(time_step);
				op_b = ext(dx_q);
			end
			OP_NY: begin
				op_a = OPW'(time_step);
				op_b = ext(dy_q);
			end
			OP_NZ: begin
				op_a = OPW'(time_step);
				op_b = ext(dz_q);
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	// write-back add/sub per step
	always_comb begin
		wb_p   = '0;
		wb_q   = m_res;
		wb_sub = 1'b0;
		case (cmd.op)
			OP_DY: begin
				wb_p   = m_res;
				wb_q   = y_q;
				wb_sub = 1'b1;
			end
			OP_DZ: begin
				wb_p   = t_q;
				wb_q   = m_res;
				wb_sub = 1'b1;
			end
			OP_NX: wb_p = x_q;
			OP_NY: wb_p = y_q;
			OP_NZ: wb_p = z_q;
			default: wb_sub = 1'b0;
		endcase
	end

	assign wb = sat_sum(wb_p, wb_q, wb_sub);

	always_comb begin
		eff_idx = restart ? '0 : cnt_q;
		if (eff_idx < first_band_end) begin
			band_d = BAND_RED;
		end else if (eff_idx < second_band_end) begin
			band_d = BAND_GREEN;
		end else begin
			band_d = BAND_BLUE;
		end
		last_d = ({1'b0, eff_idx} + 1'b1) >= {1'b0, total_steps};
	end

	leu_mul #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (cmd.mul_go),
		.a       (op_a),
		.b       (op_b),
		.frac_sh (op_frac),
		.res     (m_res),
		.sat     (m_sat),
		.done    (mul_done)
	);

	// point and run position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= ONE;
			y_q   <= ONE;
			z_q   <= ONE;
			cnt_q <= '0;
		end else if (cmd.load) begin
			if (restart) begin
				x_q <= ONE;
				y_q <= ONE;
				z_q <= ONE;
			end
		end else if (cmd.commit) begin
			case (cmd.op)
				OP_NX: x_q <= wb[W-1:0];
				OP_NY: y_q <= wb[W-1:0];
				OP_NZ: begin
					if (last_q) begin
						x_q   <= ONE;
						y_q   <= ONE;
						z_q   <= ONE;
						cnt_q <= '0;
					end else begin
						z_q   <= wb[W-1:0];
						cnt_q <= idx_q + 1'b1;
					end
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// step temporaries and output beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q  <= eff_idx;
			band_q <= band_d;
			last_q <= last_d;
			sat_q  <= rho_sat;
		end else if (cmd.mul_go) begin
			sat_q <= sat_q | go_sat;
		end else if (cmd.commit) begin
			sat_q <= sat_q | m_sat | wb[W];
			case (cmd.op)
				OP_DX: dx_q <= m_res;
				OP_DY: dy_q <= wb[W-1:0];
				OP_XY: t_q  <= m_res;
				OP_DZ: dz_q <= wb[W-1:0];
				OP_NZ: begin
					out_x_q    <= POS_W'($signed(x_q));
					out_y_q    <= POS_W'($signed(y_q));
					out_z_q    <= POS_W'($signed(wb[W-1:0]));
					out_idx_q  <= idx_q;
					out_band_q <= band_q;
					out_last_q <= last_q;
					out_sat_q  <= sat_q | m_sat | wb[W];
				end
				default: t_q <= t_q;
			endcase
		end
	end

	assign pos_x      = out_x_q;
	assign pos_y      = out_y_q;
	assign pos_z      = out_z_q;
	assign step_index = out_idx_q;
	assign color_band = out_band_q;
	assign run_last   = out_last_q;
	assign saturated  = out_sat_q;

endmodule

`default_nettype wire

// File: hdl/leu_ctrl.sv
// controller: accepts a beat, walks the seven multiply steps, hands the
// result to the output register; uses leu_pkg
`timescale 1ns / 1ps
`default_nettype none

module leu_ctrl
	import leu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	input  wire logic mul_done,
	output cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GO,
		ST_WAIT
	} state_t;

	state_t state_q;
	op_t    op_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && s_tvalid;
		cmd.mul_go = (state_q == ST_GO);
		cmd.commit = (state_q == ST_WAIT) && mul_done && ((op_q != OP_NZ) || out_free);
		cmd.op     = op_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_DX;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= OP_DX;
						state_q <= ST_GO;
					end
				end
				ST_GO: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mul_done) begin
						if (op_q == OP_NZ) begin
							if (out_free) begin
								m_tvalid_q <= 1'b1;
								state_q    <= ST_IDLE;
							end
						end else begin
							op_q    <= op_t'(op_q + 3'd1);
							state_q <= ST_GO;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	a_commit_needs_product: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> mul_done)
		else $error("write-back without a finished product");

	a_valid_from_final_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(cmd.commit && (op_q == OP_NZ)))
		else $error("output beat not produced by the last step");

	a_accept_starts_dx: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_GO) && (op_q == OP_DX))
		else $error("accepted beat did not start the first step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && (op_q == OP_NZ)) |-> out_free)
		else $error("pending output beat overwritten");

endmodule

`default_nettype wire

// File: hdl/lorenz_euler_integrator.sv
// Lorenz explicit Euler integrator: one stream beat in, one new point out per step.
// Each accepted beat (s_tdata bit 0 = restart to (1,1,1)) advances the point by one
// Euler step using seven products on one shared multiplier that consumes 16 bits of
// its second operand per cycle. The next beat is taken while the previous result
// waits in the output register. Configuration holds the coefficients, dt and the
// run and band lengths; depends on leu_pkg, leu_ctrl, leu_datapath and leu_mul.
`timescale 1ns / 1ps
`default_nettype none

module lorenz_euler_integrator
	import leu_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [ADDR_W-1:0]    cfg_addr,
	input  wire logic [COEF_W-1:0]    cfg_wdata,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,   // restart, zero fill
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [119:0]         m_tdata,   // pos_x, pos_y, pos_z, step_index, color_band, zero fill
	output logic                      m_tlast,   // run_last
	output logic                      m_tuser    // saturated
);

	logic signed [COEF_W-1:0] sigma_q, rho_q, beta_q;
	logic        [DT_W-1:0]   dt_q;
	logic        [CNT_W-1:0]  total_q, first_q, second_q;

	cmd_t              cmd;
	logic              mul_done;
	logic [POS_W-1:0]  pos_x, pos_y, pos_z;
	logic [CNT_W-1:0]  step_index;
	logic [BAND_W-1:0] color_band;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q  <= 32'sd10485760;
			rho_q    <= 32'sd29360128;
			beta_q   <= 32'sd2796133;
			dt_q     <= 20'd1049;
			total_q  <= 16'd50000;
			first_q  <= 16'd17000;
			second_q <= 16'd34000;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SIGMA:      sigma_q  <= cfg_wdata;
				REG_RHO:        rho_q    <= cfg_wdata;
				REG_BETA:       beta_q   <= cfg_wdata;
				REG_TIME_STEP:  dt_q     <= cfg_wdata[DT_W-1:0];
				REG_TOTAL:      total_q  <= cfg_wdata[CNT_W-1:0];
				REG_FIRST_END:  first_q  <= cfg_wdata[CNT_W-1:0];
				REG_SECOND_END: second_q <= cfg_wdata[CNT_W-1:0];
				default:        sigma_q  <= sigma_q;
			endcase
		end
	end

	leu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.mul_done (mul_done),
		.cmd      (cmd)
	);

	leu_datapath #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.restart         (s_tdata[0]),
		.sigma           (sigma_q),
		.rho             (rho_q),
		.beta            (beta_q),
		.time_step       (dt_q),
		.total_steps     (total_q),
		.first_band_end  (first_q),
		.second_band_end (second_q),
		.mul_done        (mul_done),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.pos_z           (pos_z),
		.step_index      (step_index),
		.color_band      (color_band),
		.run_last        (m_tlast),
		.saturated       (m_tuser)
	);

	assign m_tdata = {6'd0, color_band, step_index, pos_z, pos_y, pos_x};

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// self-checking testbench for lorenz_euler_integrator: streams restart beats, predicts
// every new point, step index, band and flags, and compares them with the result beats
// depends on leu_pkg and the lorenz_euler_integrator rtl
`timescale 1ns / 1ps

module tb_top;
	import leu_pkg::*;

	localparam int COORD_W     = 32;
	localparam int FRAC_W      = 20;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYC  = 100;

	localparam longint POS_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
	localparam longint POS_MIN = -POS_MAX - 1;
	localparam longint ONE_Q   = longint'(1) <<< FRAC_W;

	typedef struct packed {
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [POS_W-1:0]  z;
		logic [CNT_W-1:0]  idx;
		logic [BAND_W-1:0] band;
		logic              last;
		logic              sat;
	} point_beat_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [ADDR_W-1:0] cfg_addr  = '0;
	logic [COEF_W-1:0] cfg_wdata = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata   = '0;   // restart, zero fill
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [119:0]      m_tdata;          // pos_x, pos_y, pos_z, step_index, color_band, zero fill
	logic              m_tlast;          // run_last
	logic              m_tuser;          // saturated

	// register mirror and point state
	logic [COEF_W-1:0] sigma_r, rho_r, beta_r;
	logic [DT_W-1:0]   dt_r;
	logic [CNT_W-1:0]  total_r, first_end_r, second_end_r;
	longint            px, py, pz;
	logic [CNT_W-1:0]  step_cnt;
	bit                step_sat;

	bit          restart_q[$];
	point_beat_t pending_points[$];
	point_beat_t exp_b, got_b;
	int          n_queued = 0;
	int          n_taken  = 0;
	int          errors   = 0;
	int          quiet    = 0;
	bit          in_acc   = 1'b0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;

	lorenz_euler_integrator #(
		.COORD_WIDTH(COORD_W),
		.FRAC_BITS  (FRAC_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint clip(longint v);
		if (v > POS_MAX) begin
			step_sat = 1'b1;
			return POS_MAX;
		end
		if (v < POS_MIN) begin
			step_sat = 1'b1;
			return POS_MIN;
		end
		return v;
	endfunction

	// exact product, floor shift, saturate
	function automatic longint mul_shift(longint a, longint b, int sh);
		return clip((a * b) >>> sh);
	endfunction

	function automatic point_beat_t lorenz_advance(bit restart);
		longint           sig, rh, bt, dt, rho_al, dx, dy, dz, x, y, z;
		logic [CNT_W:0]   nxt;
		point_beat_t      r;
		sig = longint'($signed(sigma_r));
		rh  = longint'($signed(rho_r));
		bt  = longint'($signed(beta_r));
		dt  = longint'(dt_r);
		step_sat = 1'b0;
		if (restart) begin
			px = ONE_Q;
			py = ONE_Q;
			pz = ONE_Q;
			step_cnt = '0;
		end
		x = px;
		y = py;
		z = pz;
		if (FRAC_W >= CFG_FRAC)
			rho_al = mul_shift(rh, longint'(1) <<< (FRAC_W - CFG_FRAC), 0);
		else
			rho_al = mul_shift(rh, 1, CFG_FRAC - FRAC_W);
		dx = mul_shift(sig, clip(y - x), CFG_FRAC);
		dy = clip(mul_shift(x, clip(rho_al - z), FRAC_W) - y);
		dz = clip(mul_shift(x, y, FRAC_W) - mul_shift(bt, z, CFG_FRAC));
		x = clip(x + mul_shift(dt, dx, CFG_FRAC));
		y = clip(y + mul_shift(dt, dy, CFG_FRAC));
		z = clip(z + mul_shift(dt, dz, CFG_FRAC));
		r.x   = x[POS_W-1:0];
		r.y   = y[POS_W-1:0];
		r.z   = z[POS_W-1:0];
		r.idx = step_cnt;
		if (step_cnt < first_end_r)
			r.band = BAND_RED;
		else if (step_cnt < second_end_r)
			r.band = BAND_GREEN;
		else
			r.band = BAND_BLUE;
		nxt = {1'b0, step_cnt} + 1'b1;
		r.last = (nxt >= {1'b0, total_r});
		r.sat  = step_sat;
		px = x;
		py = y;
		pz = z;
		step_cnt = nxt[CNT_W-1:0];
		if (r.last) begin
			px = ONE_Q;
			py = ONE_Q;
			pz = ONE_Q;
			step_cnt = '0;
		end
		return r;
	endfunction

	function automatic void compare_field(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$error("%s mismatch: expected %0h, actual %0h", name, e, a);
			errors++;
		end
	endfunction

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		if (!arst_n) begin
			sigma_r      = 32'd10485760;
			rho_r        = 32'd29360128;
			beta_r       = 32'd2796133;
			dt_r         = 20'd1049;
			total_r      = 16'd50000;
			first_end_r  = 16'd17000;
			second_end_r = 16'd34000;
			px = ONE_Q;
			py = ONE_Q;
			pz = ONE_Q;
			step_cnt = '0;
			in_acc <= 1'b0;
			quiet  <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_SIGMA:      sigma_r      = cfg_wdata;
					REG_RHO:        rho_r        = cfg_wdata;
					REG_BETA:       beta_r       = cfg_wdata;
					REG_TIME_STEP:  dt_r         = cfg_wdata[DT_W-1:0];
					REG_TOTAL:      total_r      = cfg_wdata[CNT_W-1:0];
					REG_FIRST_END:  first_end_r  = cfg_wdata[CNT_W-1:0];
					REG_SECOND_END: second_end_r = cfg_wdata[CNT_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got_b.x    = m_tdata[31:0];
				got_b.y    = m_tdata[63:32];
				got_b.z    = m_tdata[95:64];
				got_b.idx  = m_tdata[111:96];
				got_b.band = m_tdata[113:112];
				got_b.last = m_tlast;
				got_b.sat  = m_tuser;
				if (pending_points.size() == 0) begin
					$error("result beat with no expected point waiting");
					errors++;
				end else begin
					exp_b = pending_points.pop_front();
					compare_field("pos_x", exp_b.x, got_b.x);
					compare_field("pos_y", exp_b.y, got_b.y);
					compare_field("pos_z", exp_b.z, got_b.z);
					compare_field("step_index", 32'(exp_b.idx), 32'(got_b.idx));
					compare_field("color_band", 32'(exp_b.band), 32'(got_b.band));
					compare_field("run_last", 32'(exp_b.last), 32'(got_b.last));
					compare_field("saturated", 32'(exp_b.sat), 32'(got_b.sat));
				end
			end
			if (s_tvalid && s_tready) begin
				pending_points.push_back(lorenz_advance(s_tdata[0]));
				n_taken++;
			end
			in_acc <= s_tvalid && s_tready;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// input beat driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_acc) begin
			if (restart_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {7'b0, restart_q.pop_front()};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side backpressure
	always @(negedge clk) begin
		m_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_config(input logic [31:0] sg, rh, bt, dtv, tot, f, s);
		write_reg(REG_SIGMA, sg);
		write_reg(REG_RHO, rh);
		write_reg(REG_BETA, bt);
		write_reg(REG_TIME_STEP, dtv);
		write_reg(REG_TOTAL, tot);
		write_reg(REG_FIRST_END, f);
		write_reg(REG_SECOND_END, s);
	endtask

	task automatic drain();
		while (n_taken != n_queued || pending_points.size() != 0)
			@(posedge clk);
	endtask

	task automatic push_beat(input bit r);
		restart_q.push_back(r);
		n_queued++;
	endtask

	task automatic run_pattern(input logic [31:0] pat, input int n);
		for (int i = 0; i < n; i++)
			push_beat(pat[i]);
		drain();
	endtask

	initial begin
		logic [31:0] sg, rh, bt, dtv, tot, f, s;
		bit          wild;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset coefficients, restart mid run
		run_pattern(32'h4, 4);
		// longest run, no red band
		set_config(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h000f_ffff,
			32'h0000_ffff, 32'h0, 32'h0000_ffff);
		run_pattern(32'h0, 2);
		// run length zero, also lowered below the current index
		set_config(32'd10485760, 32'd29360128, 32'd2796133, 32'd1049, 32'h0,
			32'd1, 32'd2);
		run_pattern(32'h0, 2);
		// bands out of order
		set_config(32'd10485760, 32'd29360128, 32'd2796133, 32'd1049, 32'd4,
			32'd2, 32'd1);
		run_pattern(32'h0, 4);
		// exact band boundaries and run wrap
		set_config(32'd10485760, 32'd29360128, 32'd2796133, 32'd20000, 32'd3,
			32'd1, 32'd2);
		run_pattern(32'h10, 7);
		// time step zero
		set_config(32'd10485760, 32'd29360128, 32'd2796133, 32'h0, 32'd2,
			32'd1, 32'd2);
		run_pattern(32'h1, 2);
		// saturating extremes
		set_config(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h000f_ffff,
			32'd3, 32'h0, 32'h0);
		run_pattern(32'h0, 3);

		for (int k = 0; k < 8; k++) begin
			case (k % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			wild = (k % 3 == 2);
			if (wild) begin
				sg  = $urandom;
				rh  = $urandom;
				bt  = $urandom;
				dtv = $urandom;
				tot = ($urandom & 32'hffff_0000) | $urandom_range(0, 60);
				f   = ($urandom & 32'hffff_0000) | $urandom_range(0, 70);
				s   = ($urandom & 32'hffff_0000) | $urandom_range(0, 70);
			end else begin
				sg  = 32'd10485760 + $urandom_range(0, 4194304) - 32'd2097152;
				rh  = 32'd29360128 + $urandom_range(0, 8388608) - 32'd4194304;
				bt  = 32'd2796133 + $urandom_range(0, 1048576) - 32'd524288;
				dtv = $urandom_range(0, 20000);
				tot = ($urandom_range(3) == 0) ? $urandom_range(100, 65535)
					: $urandom_range(1, 40);
				f   = $urandom_range(0, tot);
				s   = $urandom_range(f, tot + 1);
			end
			set_config(sg, rh, bt, dtv, tot, f, s);
			for (int j = 0; j < 94; j++)
				push_beat($urandom_range(24) == 0);
			drain();
		end

		repeat (SETTLE_CYC) @(posedge clk);
		if (errors == 0 && pending_points.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
hdl/leu_pkg.sv
hdl/leu_mul.sv
hdl/leu_datapath.sv
hdl/leu_ctrl.sv
hdl/lorenz_euler_integrator.sv
sim/tb_top.sv
